FILE: rtl/cned_pkg.sv
package cned_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;
    localparam int NSTG      = 5;   // input, blur, gradient, class, hysteresis
    localparam int PIPE      = 10;

    // floor(v / 100) for v < 25600 as (v * GRAY_RECIP) >> GRAY_SHIFT
    localparam logic [12:0] GRAY_RECIP = 13'd5243;
    localparam int          GRAY_SHIFT = 19;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_WEAK   = 2'd2;
    localparam logic [1:0] CFG_STRONG = 2'd3;

    localparam logic [1:0] SEC_H  = 2'd0;
    localparam logic [1:0] SEC_DR = 2'd1;
    localparam logic [1:0] SEC_V  = 2'd2;
    localparam logic [1:0] SEC_DL = 2'd3;

    localparam logic [1:0] CLS_NONE   = 2'd0;
    localparam logic [1:0] CLS_WEAK   = 2'd1;
    localparam logic [1:0] CLS_STRONG = 2'd2;

    typedef struct packed {
        logic                        valid;
        logic [NSTG-1:0]             en;
        logic [NSTG-1:0][COL_W-1:0]  col;
        logic [NSTG-1:0]             bord;
        logic                        last;
    } t_ctl;

endpackage

FILE: rtl/canny_edge_detector.sv
// Streaming Canny edge detector. RGB pixels enter in raster order, one transaction per
// clock while the output is not stalled, and one binary edge pixel leaves per image
// position 4*(W+1) steps later (W is the width clamped to 3..2048); a flush transaction
// (tuser = 1) after the last pixel of a frame pushes out one pending result, and a flush
// before the frame is complete is dropped without a result. Each position passes gray
// conversion, 3x3 Gaussian blur, 3x3 Sobel (|gx|+|gy| saturated at 255, four direction
// sectors), non-maximum suppression, double threshold and a single raster-order hysteresis
// pass; border pixels give 0. Throughput is one transaction per clock while the output is
// not stalled; an accepted transaction reaches the output register through the ten-stage
// control pipeline, whose last stage loads the output register, on top of the row delay.
// Line buffers are single-port-write, registered-read RAMs of 2048 columns. Write the
// configuration registers (0 width, 1 height, 2 weak, 3 strong threshold) only when no
// frame is in progress.
module canny_edge_detector
    import cned_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic [0:0]  i_s_tuser,   // mode: 0 pixel, 1 flush
    // edge output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // edge_res[0], zero fill
    output logic        o_m_tlast,   // frame_last
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // ---------------- configuration ----------------
    logic [11:0] r_img_w;
    logic [15:0] r_img_h;
    logic [7:0]  r_weak;
    logic [7:0]  r_strong;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= 12'd640;
            r_img_h  <= 16'd480;
            r_weak   <= 8'd25;
            r_strong <= 8'd180;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_img_w  <= i_cfg_data[11:0];
                CFG_HEIGHT: r_img_h  <= i_cfg_data;
                CFG_WEAK:   r_weak   <= i_cfg_data[7:0];
                CFG_STRONG: r_strong <= i_cfg_data[7:0];
                default:    r_img_w  <= r_img_w;
            endcase
        end
    end

    // effective geometry, as last column and last row
    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;
    logic [11:0]      w_eff;

    always_comb begin
        if (r_img_w < 12'd3)
            w_eff = 12'd3;
        else if (r_img_w > 12'(MAX_WIDTH))
            w_eff = 12'(MAX_WIDTH);
        else
            w_eff = r_img_w;
        w_m1 = COL_W'(w_eff - 12'd1);
        h_m1 = (r_img_h < 16'd3) ? 16'd2 : r_img_h - 16'd1;
    end

    // ---------------- flow control ----------------
    // Stage k works on the position k*(W+1) behind the input; each has its own counter.
    logic [NSTG-1:0]             r_run, n_run;
    logic [NSTG-1:0][COL_W-1:0]  r_col, n_col, pc;
    logic [NSTG-1:0][ROW_W-1:0]  r_row, n_row, pr;
    logic [NSTG-1:0]             en, lst, bord;
    logic r_out_valid, r_out_edge, r_out_last;
    logic adv, acc, step, ignore;

    assign adv        = !r_out_valid || i_m_tready;
    assign o_s_tready = adv;
    assign acc        = i_s_tvalid && adv;
    assign ignore     = r_run[0] && i_s_tuser[0];
    assign step       = acc && !ignore;

    // ---------------- position tracking ----------------
    always_comb begin
        n_run = r_run;
        n_col = r_col;
        n_row = r_row;
        for (int k = 0; k < NSTG; k++) begin
            pc[k]   = r_run[k] ? r_col[k] : '0;
            pr[k]   = r_run[k] ? r_row[k] : '0;
            lst[k]  = (pc[k] == w_m1) && (pr[k] == h_m1);
            bord[k] = (pc[k] == '0) || (pc[k] == w_m1) || (pr[k] == '0) || (pr[k] == h_m1);
        end
        en[0] = r_run[0];
        for (int k = 1; k < NSTG; k++) begin
            en[k] = r_run[k] || (en[k-1] && pc[k-1] == COL_W'(1) &&
                                 pr[k-1] == ROW_W'(1));
        end
        if (step) begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) begin
                    if (lst[k]) begin
                        n_run[k] = 1'b0;
                    end else begin
                        n_run[k] = 1'b1;
                        if (pc[k] == w_m1) begin
                            n_col[k] = '0;
                            n_row[k] = pr[k] + ROW_W'(1);
                        end else begin
                            n_col[k] = pc[k] + COL_W'(1);
                            n_row[k] = pr[k];
                        end
                    end
                end
            end
            // last output position closes the frame
            if (en[NSTG-1] && lst[NSTG-1]) begin
                n_run    = NSTG'(1);
                n_col    = '0;
                n_row    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= NSTG'(1);
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_run <= n_run;
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- control pipeline ----------------
    t_ctl r_ctl [1:PIPE];
    t_ctl new_ctl;

    always_comb begin
        new_ctl.valid = step;
        new_ctl.en    = en;
        new_ctl.col   = pc;
        new_ctl.bord  = bord;
        new_ctl.last  = lst[NSTG-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= PIPE; s++) r_ctl[s] <= '0;
        end else if (adv) begin
            r_ctl[1] <= new_ctl;
            for (int s = 2; s <= PIPE; s++) r_ctl[s] <= r_ctl[s-1];
        end
    end

    // step-enable per stage: token present and that stage active
    function automatic logic act(input t_ctl c, input int k);
        return c.valid && c.en[k];
    endfunction

    // ---------------- gray ----------------
    logic [23:0] r_rgb;
    logic [14:0] r_v;
    logic [14:0] v_sum;
    logic [27:0] gray_prod;
    logic [7:0]  r_gray;

    assign v_sum = 15'(r_rgb[7:0] * 15'd30) + 15'(r_rgb[15:8] * 15'd59) +
                   15'(r_rgb[23:16] * 15'd11) + 15'd50;
    assign gray_prod = 28'(r_v) * 28'(GRAY_RECIP);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rgb  <= i_s_tdata;
            r_v    <= v_sum;
            r_gray <= gray_prod[GRAY_SHIFT +: 8];
        end
    end

    // ---------------- blur: gray line buffer, window ----------------
    logic [15:0]            g_rd;
    logic [2:0][2:0][7:0]   r_gw;
    logic [11:0]            b_sum;
    logic [7:0]             r_blur;
    logic                   g_we;

    assign g_we = adv && act(r_ctl[3], 0);

    cned_ram #(.DW(16), .AW(COL_W)) u_gray_lb (
        .i_clk  (i_clk),
        .i_we   (g_we),
        .i_waddr(r_ctl[3].col[0]),
        .i_wdata({g_rd[7:0], r_gray}),
        .i_re   (adv && act(r_ctl[2], 0)),
        .i_raddr(r_ctl[2].col[0]),
        .o_rdata(g_rd)
    );

    assign b_sum = 12'(r_gw[0][0]) + {3'b0, r_gw[0][1], 1'b0} + 12'(r_gw[0][2]) +
                   {3'b0, r_gw[1][0], 1'b0} + {2'b0, r_gw[1][1], 2'b0} +
                   {3'b0, r_gw[1][2], 1'b0} + 12'(r_gw[2][0]) +
                   {3'b0, r_gw[2][1], 1'b0} + 12'(r_gw[2][2]);

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            for (int r = 0; r < 3; r++) begin
                r_gw[r][0] <= r_gw[r][1];
                r_gw[r][1] <= r_gw[r][2];
            end
            r_gw[0][2] <= g_rd[15:8];
            r_gw[1][2] <= g_rd[7:0];
            r_gw[2][2] <= r_gray;
        end
        if (adv) begin
            r_blur <= r_ctl[4].bord[1] ? 8'd0 : b_sum[11:4];
        end
    end

    // ---------------- gradient: blur line buffer, window ----------------
    logic [15:0]          b_rd;
    logic [2:0][2:0][7:0] r_bw;
    logic                 b_we;
    logic [9:0]           gxp, gxn, gyp, gyn, ax, ay;
    logic [10:0]          mag_sum;
    logic [7:0]           mag;
    logic [1:0]           sec;
    logic [19:0]          ay256, ax106, ax618;
    logic [9:0]           r_ms;   // sector[9:8], magnitude[7:0]

    assign b_we = adv && act(r_ctl[5], 1);

    cned_ram #(.DW(16), .AW(COL_W)) u_blur_lb (
        .i_clk  (i_clk),
        .i_we   (b_we),
        .i_waddr(r_ctl[5].col[1]),
        .i_wdata({b_rd[7:0], r_blur}),
        .i_re   (adv && act(r_ctl[4], 1)),
        .i_raddr(r_ctl[4].col[1]),
        .o_rdata(b_rd)
    );

    always_comb begin
        gxp = 10'(r_bw[0][2]) + {1'b0, r_bw[1][2], 1'b0} + 10'(r_bw[2][2]);
        gxn = 10'(r_bw[0][0]) + {1'b0, r_bw[1][0], 1'b0} + 10'(r_bw[2][0]);
        gyp = 10'(r_bw[2][0]) + {1'b0, r_bw[2][1], 1'b0} + 10'(r_bw[2][2]);
        gyn = 10'(r_bw[0][0]) + {1'b0, r_bw[0][1], 1'b0} + 10'(r_bw[0][2]);
        ax  = (gxp >= gxn) ? gxp - gxn : gxn - gxp;
        ay  = (gyp >= gyn) ? gyp - gyn : gyn - gyp;
        mag_sum = 11'(ax) + 11'(ay);
        mag     = (mag_sum > 11'd255) ? 8'd255 : mag_sum[7:0];
        ay256   = {2'b0, ay, 8'b0};
        ax106   = 20'(ax) * 20'd106;
        ax618   = 20'(ax) * 20'd618;
        if (ay256 <= ax106)
            sec = SEC_H;
        else if (ay256 >= ax618)
            sec = SEC_V;
        else if ((gxp > gxn) == (gyp > gyn))
            sec = SEC_DR;
        else
            sec = SEC_DL;
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            for (int r = 0; r < 3; r++) begin
                r_bw[r][0] <= r_bw[r][1];
                r_bw[r][1] <= r_bw[r][2];
            end
            r_bw[0][2] <= b_rd[15:8];
            r_bw[1][2] <= b_rd[7:0];
            r_bw[2][2] <= r_blur;
        end
        if (adv) begin
            r_ms <= r_ctl[6].bord[2] ? 10'd0 : {sec, mag};
        end
    end

    // ---------------- suppression + threshold ----------------
    logic [19:0]          m_rd;
    logic [2:0][2:0][9:0] r_mw;
    logic                 m_we;
    logic [7:0]           mc, nq, nr, ms;
    logic [1:0]           cls;
    logic [1:0]           r_cls;

    assign m_we = adv && act(r_ctl[7], 2);

    cned_ram #(.DW(20), .AW(COL_W)) u_mag_lb (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(r_ctl[7].col[2]),
        .i_wdata({m_rd[9:0], r_ms}),
        .i_re   (adv && act(r_ctl[6], 2)),
        .i_raddr(r_ctl[6].col[2]),
        .o_rdata(m_rd)
    );

    always_comb begin
        mc = r_mw[1][1][7:0];
        case (r_mw[1][1][9:8])
            SEC_H:   begin nq = r_mw[1][0][7:0]; nr = r_mw[1][2][7:0]; end
            SEC_DR:  begin nq = r_mw[0][0][7:0]; nr = r_mw[2][2][7:0]; end
            SEC_V:   begin nq = r_mw[0][1][7:0]; nr = r_mw[2][1][7:0]; end
            default: begin nq = r_mw[0][2][7:0]; nr = r_mw[2][0][7:0]; end
        endcase
        if (r_ctl[8].bord[3] || mc < nq || mc < nr)
            ms = 8'd0;
        else
            ms = mc;
        if (ms >= r_strong)
            cls = CLS_STRONG;
        else if (ms >= r_weak)
            cls = CLS_WEAK;
        else
            cls = CLS_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            for (int r = 0; r < 3; r++) begin
                r_mw[r][0] <= r_mw[r][1];
                r_mw[r][1] <= r_mw[r][2];
            end
            r_mw[0][2] <= m_rd[19:10];
            r_mw[1][2] <= m_rd[9:0];
            r_mw[2][2] <= r_ms;
        end
        if (adv) begin
            r_cls <= cls;
        end
    end

    // ---------------- hysteresis ----------------
    logic [3:0]           c_rd;
    logic [2:0][2:0][1:0] r_cw;
    logic                 c_we;
    logic                 f_rd;
    logic [2:0]           r_fw;      // final edges of the row above, columns x-1..x+1
    logic                 r_left;
    logic                 fe_we, edge_bit, nb_edge;

    assign c_we  = adv && act(r_ctl[9], 3);
    assign fe_we = adv && act(r_ctl[10], 4);

    cned_ram #(.DW(4), .AW(COL_W)) u_class_lb (
        .i_clk  (i_clk),
        .i_we   (c_we),
        .i_waddr(r_ctl[9].col[3]),
        .i_wdata({c_rd[1:0], r_cls}),
        .i_re   (adv && act(r_ctl[8], 3)),
        .i_raddr(r_ctl[8].col[3]),
        .o_rdata(c_rd)
    );

    cned_ram #(.DW(1), .AW(COL_W)) u_final_lb (
        .i_clk  (i_clk),
        .i_we   (fe_we),
        .i_waddr(r_ctl[10].col[4]),
        .i_wdata(edge_bit),
        .i_re   (adv && act(r_ctl[8], 4)),
        .i_raddr(r_ctl[8].col[4] + COL_W'(1)),
        .o_rdata(f_rd)
    );

    always_comb begin
        nb_edge = (|r_fw) || r_left || (r_cw[1][2] == CLS_STRONG) ||
                  (r_cw[2][0] == CLS_STRONG) || (r_cw[2][1] == CLS_STRONG) ||
                  (r_cw[2][2] == CLS_STRONG);
        if (r_ctl[10].bord[4])
            edge_bit = 1'b0;
        else if (r_cw[1][1] == CLS_STRONG)
            edge_bit = 1'b1;
        else if (r_cw[1][1] == CLS_WEAK)
            edge_bit = nb_edge;
        else
            edge_bit = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            for (int r = 0; r < 3; r++) begin
                r_cw[r][0] <= r_cw[r][1];
                r_cw[r][1] <= r_cw[r][2];
            end
            r_cw[0][2] <= c_rd[3:2];
            r_cw[1][2] <= c_rd[1:0];
            r_cw[2][2] <= r_cls;
        end
        // last column reads one past the row end: that neighbor is a border, so 0
        if (adv && act(r_ctl[9], 4)) begin
            r_fw <= {(r_ctl[9].col[4] == w_m1) ? 1'b0 : f_rd, r_fw[2:1]};
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_left      <= 1'b0;
        end else if (adv) begin
            r_out_valid <= act(r_ctl[10], 4);
            if (fe_we) begin
                r_left <= edge_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe_we) begin
            r_out_edge <= edge_bit;
            r_out_last <= r_ctl[10].last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_edge};
    assign o_m_tlast  = r_out_last;

    // ---------------- assertions ----------------
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && en[NSTG-1] && lst[NSTG-1]) |=> (r_run == NSTG'(1)))
        else $error("frame end did not restart position counters");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_ctl[PIPE].valid && r_ctl[PIPE].en[NSTG-1]))
        else $error("output transaction without a hysteresis token");

    a_out_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && act(r_ctl[PIPE], 4)) |=>
        (o_m_tvalid && (o_m_tlast == $past(r_ctl[PIPE].last))))
        else $error("frame_last does not follow its token");

endmodule

FILE: rtl/cned_ram.sv
module cned_ram #(
    parameter int DW = 8,
    parameter int AW = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            // write-first on a same-address collision
            r_rdata <= (i_we && (i_waddr == i_raddr)) ? i_wdata : r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: verif/canny_edge_detector_tb.sv
module canny_edge_detector_tb;
    import cned_pkg::*;

    localparam int RING      = 2 * MAX_WIDTH + 4;
    localparam int LIMIT     = 1000000;
    localparam int N_ITEMS   = 1150;
    localparam int DRAIN_CYC = 40;    // extra idle time after the last expected output
    localparam int HOLD_CYC  = 400;   // long output hold-off for the back-pressure test

    typedef struct {
        logic       mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct {
        logic edge_bit;
        logic frame_end;
    } t_edge_px;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;
    logic [0:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_WIDTH;
    logic [15:0] i_cfg_data = '0;

    canny_edge_detector DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // pending pixel transactions and predicted edge pixels
    t_pixel   pixel_q[$];
    t_edge_px edge_q[$];
    t_pixel   in_flight;
    int       fail_cnt = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    bit       hold_req = 1'b0;
    bit       hold_done = 1'b0;
    int       hold_cnt = 0;
    int       cycle_cnt = 0;

    // edge predictor state
    logic [15:0] width_reg = 16'd640;
    logic [15:0] height_reg = 16'd480;
    logic [7:0]  weak_reg = 8'd25;
    logic [7:0]  strong_reg = 8'd180;
    int          in_col = 0;
    int          in_row = 0;
    byte unsigned gray_mem[RING];
    byte unsigned blur_mem[RING];
    byte unsigned mag_mem[RING];
    logic [1:0]   sec_mem[RING];
    logic [1:0]   cls_mem[RING];
    logic         fin_mem[RING];

    function automatic int ring_idx(longint pos);
        longint m;
        m = pos % RING;
        if (m < 0) m += RING;
        return int'(m);
    endfunction

    function automatic bit is_border(longint pos, int w, int h);
        longint y, x;
        y = pos / w;
        x = pos % w;
        return x == 0 || x == w - 1 || y == 0 || y == h - 1;
    endfunction

    function automatic int eff_width();
        int w;
        w = int'(width_reg[11:0]);
        if (w < 3) w = 3;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = int'(height_reg);
        return (h < 3) ? 3 : h;
    endfunction

    function automatic void blur_at(longint pos, int w, int h);
        int sum, kw;
        sum = 0;
        if (!is_border(pos, w, h))
            for (int dy = -1; dy <= 1; dy++)
                for (int dx = -1; dx <= 1; dx++) begin
                    kw = (dy == 0 ? 2 : 1) * (dx == 0 ? 2 : 1);
                    sum += kw * int'(gray_mem[ring_idx(pos + dy * w + dx)]);
                end
        blur_mem[ring_idx(pos)] = byte'(sum >> 4);
    endfunction

    function automatic void gradient_at(longint pos, int w, int h);
        int gx, gy, ax, ay, mag, v;
        logic [1:0] sec;
        gx = 0;
        gy = 0;
        if (is_border(pos, w, h)) begin
            mag_mem[ring_idx(pos)] = 8'd0;
            sec_mem[ring_idx(pos)] = SEC_H;
            return;
        end
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++) begin
                v = int'(blur_mem[ring_idx(pos + dy * w + dx)]);
                gx += dx * (dy == 0 ? 2 : 1) * v;
                gy += dy * (dx == 0 ? 2 : 1) * v;
            end
        ax = gx < 0 ? -gx : gx;
        ay = gy < 0 ? -gy : gy;
        mag = ax + ay;
        if (mag > 255) mag = 255;
        if (256 * ay <= 106 * ax)      sec = SEC_H;
        else if (256 * ay >= 618 * ax) sec = SEC_V;
        else                           sec = ((gx > 0) == (gy > 0)) ? SEC_DR : SEC_DL;
        mag_mem[ring_idx(pos)] = byte'(mag);
        sec_mem[ring_idx(pos)] = sec;
    endfunction

    // non-maximum suppression, then double threshold (strong tested first)
    function automatic void classify_at(longint pos, int w, int h);
        int m, qa, qb;
        longint a, b;
        m = 0;
        if (!is_border(pos, w, h)) begin
            case (sec_mem[ring_idx(pos)])
                SEC_H:   begin a = -1;     b = 1;     end
                SEC_DR:  begin a = -w - 1; b = w + 1; end
                SEC_V:   begin a = -w;     b = w;     end
                default: begin a = -w + 1; b = w - 1; end
            endcase
            m  = int'(mag_mem[ring_idx(pos)]);
            qa = int'(mag_mem[ring_idx(pos + a)]);
            qb = int'(mag_mem[ring_idx(pos + b)]);
            if (m < qa || m < qb) m = 0;
        end
        if (m >= int'(strong_reg))    cls_mem[ring_idx(pos)] = CLS_STRONG;
        else if (m >= int'(weak_reg)) cls_mem[ring_idx(pos)] = CLS_WEAK;
        else                          cls_mem[ring_idx(pos)] = CLS_NONE;
    endfunction

    // single raster-order hysteresis: earlier neighbors final, later ones strong
    function automatic logic hysteresis_at(longint pos, int w, int h);
        logic e;
        logic [1:0] c;
        e = 1'b0;
        if (!is_border(pos, w, h)) begin
            c = cls_mem[ring_idx(pos)];
            if (c == CLS_STRONG)
                e = 1'b1;
            else if (c == CLS_WEAK)
                e = fin_mem[ring_idx(pos - w - 1)] || fin_mem[ring_idx(pos - w)] ||
                    fin_mem[ring_idx(pos - w + 1)] || fin_mem[ring_idx(pos - 1)] ||
                    cls_mem[ring_idx(pos + 1)] == CLS_STRONG ||
                    cls_mem[ring_idx(pos + w - 1)] == CLS_STRONG ||
                    cls_mem[ring_idx(pos + w)] == CLS_STRONG ||
                    cls_mem[ring_idx(pos + w + 1)] == CLS_STRONG;
        end
        fin_mem[ring_idx(pos)] = e;
        return e;
    endfunction

    function automatic void predict_edges(t_pixel it);
        int w, h;
        longint n, p, lag, pos;
        t_edge_px px;
        w = eff_width();
        h = eff_height();
        n = longint'(w) * h;
        p = longint'(in_row) * w + in_col;
        lag = w + 1;
        if (p < n) begin
            if (it.mode) return;    // flush before the frame is complete: dropped
            gray_mem[ring_idx(p)] = byte'((int'(it.red) * 30 + int'(it.green) * 59 +
                                           int'(it.blue) * 11 + 50) / 100);
        end
        for (int k = 1; k <= 3; k++) begin
            pos = p - k * lag;
            if (pos < 0 || pos >= n) continue;
            if (k == 1)      blur_at(pos, w, h);
            else if (k == 2) gradient_at(pos, w, h);
            else             classify_at(pos, w, h);
        end
        pos = p - 4 * lag;
        if (pos >= 0 && pos < n) begin
            px.edge_bit  = hysteresis_at(pos, w, h);
            px.frame_end = (pos == n - 1);
            edge_q.push_back(px);
        end
        if (pos >= n - 1) begin
            in_col = 0;
            in_row = 0;
        end else begin
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
    endfunction

    // input driver: predicts on each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                predict_edges(in_flight);
            if (!i_s_tvalid || o_s_tready) begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_flight = pixel_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {in_flight.blue, in_flight.green, in_flight.red};
                    i_s_tuser  <= in_flight.mode;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output ready, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            i_m_tready <= 1'b0;
            hold_cnt   <= hold_cnt - 1;
        end else if (hold_req && !hold_done) begin
            i_m_tready <= 1'b0;
            hold_cnt   <= HOLD_CYC;
            hold_done  <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // output monitor: compare each transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_edge_px want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (edge_q.size() == 0) begin
                $error("unexpected edge pixel: edge_res=%0b frame_last=%0b",
                       o_m_tdata[0], o_m_tlast);
                fail_cnt++;
            end else begin
                want = edge_q.pop_front();
                if (o_m_tdata[0] !== want.edge_bit) begin
                    $error("edge_res: expected %0b, got %0b", want.edge_bit, o_m_tdata[0]);
                    fail_cnt++;
                end
                if (o_m_tlast !== want.frame_end) begin
                    $error("frame_last: expected %0b, got %0b", want.frame_end, o_m_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // one write per call; valid drops for a cycle before the next write
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:  width_reg  = {4'd0, val[11:0]};
            CFG_HEIGHT: height_reg = val;
            CFG_WEAK:   weak_reg   = val[7:0];
            default:    strong_reg = val[7:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (pixel_q.size() > 0 || i_s_tvalid || edge_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    function automatic void push_px(logic mode, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_pixel it;
        it.mode  = mode;
        it.red   = r;
        it.green = g;
        it.blue  = b;
        pixel_q.push_back(it);
    endfunction

    // one frame at the current geometry; returns the number of queued items
    function automatic int queue_frame(bit blocky);
        int w, h, stripe, cnt;
        logic [7:0] lvl, lo, hi;
        w = eff_width();
        h = eff_height();
        cnt = 0;
        lo = 8'($urandom_range(60));
        hi = 8'($urandom_range(255, 120));
        stripe = int'($urandom_range(4, 1));
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++) begin
                // stray early flushes must be ignored
                if ($urandom_range(99) < 4) begin
                    push_px(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
                    cnt++;
                end
                if (blocky) begin
                    lvl = (((x + y * stripe) / 2) % 3 == 0) ? hi : lo;
                    lvl = lvl ^ 8'($urandom_range(7));
                    push_px(1'b0, lvl, lvl ^ 8'($urandom_range(3)), lvl);
                end else begin
                    push_px(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
                end
                cnt++;
            end
        // drain rows; a pixel past the frame end acts as a flush
        for (int i = 0; i < 4 * (w + 1); i++) begin
            if ($urandom_range(99) < 10)
                push_px(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
            else
                push_px(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
            cnt++;
        end
        return cnt;
    endfunction

    initial begin
        int sent, frame_no;
        for (int i = 0; i < RING; i++) begin
            gray_mem[i] = 8'd0;
            blur_mem[i] = 8'd0;
            mag_mem[i]  = 8'd0;
            sec_mem[i]  = SEC_H;
            cls_mem[i]  = CLS_NONE;
            fin_mem[i]  = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: widths/heights below range clamp to 3x3, extreme thresholds
        write_reg(CFG_HEIGHT, 16'hFFFF);
        write_reg(CFG_WIDTH, 16'd0);
        write_reg(CFG_HEIGHT, 16'd2);
        write_reg(CFG_WEAK, 16'd0);
        write_reg(CFG_STRONG, 16'd255);
        push_px(1'b1, 8'hFF, 8'hFF, 8'hFF);    // flush too early
        push_px(1'b0, 8'h00, 8'h00, 8'h00);
        push_px(1'b0, 8'hFF, 8'hFF, 8'hFF);
        push_px(1'b0, 8'hFF, 8'h00, 8'h00);
        push_px(1'b0, 8'h00, 8'hFF, 8'h00);
        push_px(1'b0, 8'h00, 8'h00, 8'hFF);
        push_px(1'b0, 8'hAA, 8'h55, 8'hAA);
        push_px(1'b0, 8'h55, 8'hAA, 8'h55);
        push_px(1'b0, 8'hFF, 8'hFF, 8'hFF);
        push_px(1'b0, 8'h01, 8'h80, 8'h7F);
        for (int i = 0; i < 16; i++)
            push_px(i[0], 8'($urandom), 8'($urandom), 8'($urandom));
        sent = pixel_q.size();
        wait_idle();

        // wide frame with a long output hold-off so the input stalls
        write_reg(CFG_WIDTH, 16'd40);
        write_reg(CFG_HEIGHT, 16'd3);
        write_reg(CFG_WEAK, 16'd20);
        write_reg(CFG_STRONG, 16'd0);
        sent += queue_frame(1'b1);
        hold_req = 1'b1;
        wait_idle();

        frame_no = 0;
        while (sent < N_ITEMS) begin
            case (frame_no % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            write_reg(CFG_WIDTH, ($urandom_range(9) == 0) ? 16'($urandom_range(2))
                                                          : 16'($urandom_range(12, 3)));
            write_reg(CFG_HEIGHT, 16'($urandom_range(8, 2)));
            write_reg(CFG_WEAK, ($urandom_range(7) == 0) ? 16'd255 : 16'($urandom_range(90)));
            write_reg(CFG_STRONG, ($urandom_range(7) == 0) ? 16'd0
                                                           : 16'($urandom_range(255, 40)));
            sent += queue_frame($urandom_range(2) != 0);
            wait_idle();
            frame_no++;
        end

        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
